/* hdl/rti_pkg.sv */
// Shared types and constants of the ray/triangle intersection block.
// Holds the request and result structs; no dependencies.
package rti_pkg;

  localparam int unsigned VecBits  = 63;
  localparam int unsigned TagBits  = 16;
  localparam int unsigned BaryBits = 17;
  localparam int unsigned EpsBits  = 16;

  // One request: ray, triangle and a tag, each vector as packed x, y, z (x lowest)
  typedef struct packed {
    logic [TagBits-1:0] face_tag;
    logic [VecBits-1:0] vertex_two;
    logic [VecBits-1:0] vertex_one;
    logic [VecBits-1:0] vertex_zero;
    logic [VecBits-1:0] ray_direction;
    logic [VecBits-1:0] ray_origin;
  } rti_req_t;

  // One result
  typedef struct packed {
    logic                hit;
    logic [TagBits-1:0]  result_tag;
    logic [BaryBits-1:0] bary_u;
    logic [BaryBits-1:0] bary_v;
    logic [VecBits-1:0]  hit_point;
  } rti_rsp_t;

endpackage

/* hdl/rti_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; used by ray_triangle_intersection for u, v and the hit point.
module rti_div #(
  parameter int DEN_W = 69,
  parameter int QB    = 23
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [DEN_W+QB-1:0]   num_i,
  input  logic [DEN_W-1:0]      den_i,
  output logic [QB-1:0]         quo_o
);

  localparam int RW = DEN_W + QB;

  logic [RW-1:0]    rem_q [QB];
  logic [DEN_W-1:0] den_q [QB];
  logic [QB-1:0]    quo_q [QB];

  for (genvar j = 0; j < QB; j++) begin : g_stage
    logic [RW-1:0]    rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QB-1:0]    quo_in;
    logic [RW-1:0]    trial;
    logic [RW:0]      diff;
    logic [RW-1:0]    rem_d;
    logic [QB-1:0]    quo_d;

    if (j == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    // Try to subtract the divisor aligned to this quotient bit
    assign trial = RW'(den_in) << (QB - 1 - j);
    assign diff  = {1'b0, rem_in} - {1'b0, trial};

    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      if (!diff[RW]) begin
        rem_d = diff[RW-1:0];
        quo_d[QB-1-j] = 1'b1;
      end
    end

    // Advance with the pipeline
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d;
        den_q[j] <= den_in;
        quo_q[j] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[QB-1];

endmodule

/* hdl/ray_triangle_intersection.sv */
// Fixed-point ray/triangle intersection test, one request per cycle while in_ready_o is high.
// The quotient stages of the five dividers set the pipeline depth.
// Throughput: one request per cycle; a one-entry skid absorbs an output stall, then in_ready_o drops.
// Reset: clears all valid bits and the output/skid flags, and sets epsilon to 1.
// Depends on rti_pkg and rti_div.
module ray_triangle_intersection #(
  parameter int COORD_BITS     = 21,
  parameter int FRAC_BITS      = 12,
  parameter int BARY_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rti_pkg::rti_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rti_pkg::rti_rsp_t  out_rsp_o
);

  import rti_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int B   = BARY_FRAC_BITS;
  localparam int EDW = C + 1;
  localparam int QW  = 2 * C + 3;
  localparam int LO  = C + 2;
  localparam int PLW = 2 * C + 4;
  localparam int PHW = 2 * C + 2;
  localparam int WW  = 3 * C + 6;
  localparam int SW1 = WW + 1;
  localparam int D   = (C + 2 > B + 1) ? C + 2 : B + 1;
  localparam int AL  = (WW + 1) / 2;
  localparam int AH  = WW - AL;
  localparam int AEW = WW + EpsBits;
  localparam int TW  = WW + EpsBits + 1;
  localparam int XW  = (WW > EpsBits + 2 * F) ? WW : EpsBits + 2 * F;
  localparam int RW  = WW + D;
  localparam int NW  = WW + C;
  localparam int MW  = 6 * C + TagBits;
  localparam int SDW = MW + 4;
  localparam int NS  = 9 + D;
  localparam int STW = C + 2;
  localparam int PW  = C + 3;

  localparam logic [D-1:0]         TLIM = D'(1) << (C + 1);
  localparam logic signed [PW-1:0] PMAX = PW'((1 << (C - 1)) - 1);
  localparam logic signed [PW-1:0] PMIN = PW'(-(1 << (C - 1)));

  // Handshake and epsilon
  logic                 en;
  logic [NS-1:0]        v_q;
  logic [EpsBits-1:0]   eps_q;
  logic                 out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  rti_rsp_t             out_q, skid_q, rsp;
  logic                 pop, arrive, out_from_skid, out_from_pipe, skid_load;

  assign en         = ~skid_valid_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsBits'(1);
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  // Shift valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  // Stage 1: unpack, form edges and origin offset
  logic signed [C-1:0]   c_p0 [3], c_p1 [3], c_p2 [3], c_o [3];
  logic signed [EDW-1:0] e1_d [3], e2_d [3], s_d [3];
  logic signed [EDW-1:0] e1_q [3], e2_q [3], s_q [3];
  logic [MW-1:0]         meta_d;
  logic [MW-1:0]         meta_q [9];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_p0[k] = $signed(in_req_i.vertex_zero[k*C +: C]);
      c_p1[k] = $signed(in_req_i.vertex_one[k*C +: C]);
      c_p2[k] = $signed(in_req_i.vertex_two[k*C +: C]);
      c_o[k]  = $signed(in_req_i.ray_origin[k*C +: C]);
      e1_d[k] = EDW'(c_p1[k]) - EDW'(c_p0[k]);
      e2_d[k] = EDW'(c_p2[k]) - EDW'(c_p0[k]);
      s_d[k]  = EDW'(c_o[k]) - EDW'(c_p0[k]);
    end
    meta_d = {in_req_i.face_tag, in_req_i.ray_direction[3*C-1:0],
              in_req_i.ray_origin[3*C-1:0]};
  end

  // Stage 2: cross products h = dir x e2, q = s x e1
  logic signed [EDW-1:0] dv [3];
  logic signed [QW-1:0]  h [3], q [3];
  logic signed [EDW-1:0] x_d [4][3], x_q [4][3];
  logic signed [QW-1:0]  y_d [4][3], y_q [4][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dv[k] = EDW'($signed(meta_q[0][3*C + k*C +: C]));
    end
    h[0] = QW'(dv[1] * e2_q[2]) - QW'(dv[2] * e2_q[1]);
    h[1] = QW'(dv[2] * e2_q[0]) - QW'(dv[0] * e2_q[2]);
    h[2] = QW'(dv[0] * e2_q[1]) - QW'(dv[1] * e2_q[0]);
    q[0] = QW'(s_q[1] * e1_q[2]) - QW'(s_q[2] * e1_q[1]);
    q[1] = QW'(s_q[2] * e1_q[0]) - QW'(s_q[0] * e1_q[2]);
    q[2] = QW'(s_q[0] * e1_q[1]) - QW'(s_q[1] * e1_q[0]);
    for (int k = 0; k < 3; k++) begin
      x_d[0][k] = e1_q[k];
      x_d[1][k] = s_q[k];
      x_d[2][k] = dv[k];
      x_d[3][k] = e2_q[k];
      y_d[0][k] = h[k];
      y_d[1][k] = h[k];
      y_d[2][k] = q[k];
      y_d[3][k] = q[k];
    end
  end

  // Stage 3: dot-product terms as low and high partial products
  logic signed [PLW-1:0] pl_d [4][3], pl_q [4][3];
  logic signed [PHW-1:0] ph_d [4][3], ph_q [4][3];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 3; k++) begin
        pl_d[i][k] = PLW'(x_q[i][k] * $signed({1'b0, y_q[i][k][LO-1:0]}));
        ph_d[i][k] = PHW'(x_q[i][k] * $signed(y_q[i][k][QW-1:LO]));
      end
    end
  end

  // Stage 4: merge partial products; stage 5: sum the terms
  logic signed [WW-1:0] pr_d [4][3], pr_q [4][3];
  logic signed [WW-1:0] dt_d [4], dt_q [4];
  logic signed [WW-1:0] n_d [4], n_q [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 3; k++) begin
        pr_d[i][k] = (WW'(ph_q[i][k]) <<< LO) + WW'(pl_q[i][k]);
      end
      dt_d[i] = pr_q[i][0] + pr_q[i][1] + pr_q[i][2];
    end
  end

  // Stage 6: flip all numerators so the determinant is not negative
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      n_d[i] = dt_q[0] < 0 ? -dt_q[i] : dt_q[i];
    end
  end

  // Stage 7: range tests, a*eps and |e2q|*|dir| partial products
  logic [WW-1:0]        a6_u, em;
  logic [C-1:0]         dm [3];
  logic signed [C-1:0]  dk [3];
  logic                 rej7_d, rej7_q, rej8_q;
  logic signed [WW-1:0] a7_q, sh7_q, dq7_q, e7_q;
  logic [AL+EpsBits-1:0] ael_d, ael_q;
  logic [AH+EpsBits-1:0] aeh_d, aeh_q;
  logic [AL+C-1:0]      tml_d [3], tml_q [3];
  logic [AH+C-1:0]      tmh_d [3], tmh_q [3];

  always_comb begin
    a6_u   = n_q[0][WW-1:0];
    rej7_d = (n_q[0] == 0)
          || (XW'(a6_u) < (XW'(eps_q) << (2 * F)))
          || (n_q[1] < 0) || (n_q[1] > n_q[0]) || (n_q[2] < 0)
          || ((SW1'(n_q[1]) + SW1'(n_q[2])) > SW1'(n_q[0]));
    em     = n_q[3][WW-1] ? WW'(-n_q[3]) : n_q[3][WW-1:0];
    ael_d  = (AL+EpsBits)'(a6_u[AL-1:0] * eps_q);
    aeh_d  = (AH+EpsBits)'(a6_u[WW-1:AL] * eps_q);
    for (int k = 0; k < 3; k++) begin
      dk[k]    = $signed(meta_q[5][3*C + k*C +: C]);
      dm[k]    = dk[k][C-1] ? C'(-dk[k]) : $unsigned(dk[k]);
      tml_d[k] = (AL+C)'(em[AL-1:0] * dm[k]);
      tmh_d[k] = (AH+C)'(em[WW-1:AL] * dm[k]);
    end
  end

  // Stage 8: merge the wide products
  logic signed [WW-1:0] a8_q, sh8_q, dq8_q, e8_q;
  logic [AEW-1:0]       ae8_d, ae8_q;
  logic [NW-1:0]        nk8_d [3], nk8_q [3];

  always_comb begin
    ae8_d = (AEW'(aeh_q) << AL) + AEW'(ael_q);
    for (int k = 0; k < 3; k++) begin
      nk8_d[k] = (NW'(tmh_q[k]) << AL) + NW'(tml_q[k]);
    end
  end

  // Stage 9: distance test, quotient overflow, divider operands
  logic                 t_ok, hit9_d, hit9_q;
  logic [2:0]           ovf9_d, ovf9_q;
  logic [RW-1:0]        dnu_d, dnv_d, dnu_q, dnv_q;
  logic [RW-1:0]        dnt_q [3];
  logic [WW-1:0]        den_d, den_q;

  always_comb begin
    den_d  = a8_q[WW-1:0];
    t_ok   = (TW'(e8_q) <<< F) > $signed({1'b0, ae8_q});
    hit9_d = !rej8_q && t_ok;
    for (int k = 0; k < 3; k++) begin
      ovf9_d[k] = RW'(nk8_q[k]) >= (RW'(den_d) << D);
    end
    dnu_d = RW'(sh8_q[WW-1:0]) << B;
    dnv_d = RW'(dq8_q[WW-1:0]) << B;
  end

  // Sideband that runs beside the dividers
  logic [SDW-1:0] side_q [D];

  // Pipeline data registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_q    <= e1_d;
      e2_q    <= e2_d;
      s_q     <= s_d;
      meta_q[0] <= meta_d;
      for (int k = 1; k < 9; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
      x_q     <= x_d;
      y_q     <= y_d;
      pl_q    <= pl_d;
      ph_q    <= ph_d;
      pr_q    <= pr_d;
      dt_q    <= dt_d;
      n_q     <= n_d;
      rej7_q  <= rej7_d;
      a7_q    <= n_q[0];
      sh7_q   <= n_q[1];
      dq7_q   <= n_q[2];
      e7_q    <= n_q[3];
      ael_q   <= ael_d;
      aeh_q   <= aeh_d;
      tml_q   <= tml_d;
      tmh_q   <= tmh_d;
      rej8_q  <= rej7_q;
      a8_q    <= a7_q;
      sh8_q   <= sh7_q;
      dq8_q   <= dq7_q;
      e8_q    <= e7_q;
      ae8_q   <= ae8_d;
      nk8_q   <= nk8_d;
      hit9_q  <= hit9_d;
      ovf9_q  <= ovf9_d;
      dnu_q   <= dnu_d;
      dnv_q   <= dnv_d;
      for (int k = 0; k < 3; k++) begin
        dnt_q[k] <= RW'(nk8_q[k]);
      end
      den_q   <= den_d;
      side_q[0] <= {meta_q[8], hit9_q, ovf9_q};
      for (int j = 1; j < D; j++) begin
        side_q[j] <= side_q[j-1];
      end
    end
  end

  // Dividers: u, v and the three distance steps
  logic [D-1:0] qu, qv;
  logic [D-1:0] qt [3];

  rti_div #(.DEN_W(WW), .QB(D)) u_div_u (
    .clk_i(clk_i), .en_i(en), .num_i(dnu_q), .den_i(den_q), .quo_o(qu)
  );
  rti_div #(.DEN_W(WW), .QB(D)) u_div_v (
    .clk_i(clk_i), .en_i(en), .num_i(dnv_q), .den_i(den_q), .quo_o(qv)
  );
  for (genvar k = 0; k < 3; k++) begin : g_tdiv
    rti_div #(.DEN_W(WW), .QB(D)) u_div_t (
      .clk_i(clk_i), .en_i(en), .num_i(dnt_q[k]), .den_i(den_q), .quo_o(qt[k])
    );
  end

  // Final: clamp step, add origin, saturate, zero on miss
  logic                  hitf;
  logic [STW-1:0]        step [3];
  logic signed [PW-1:0]  stp [3], pt [3], ps [3];
  logic [VecBits-1:0]    hp;

  always_comb begin
    hitf = side_q[D-1][3];
    hp   = '0;
    for (int k = 0; k < 3; k++) begin
      step[k] = (side_q[D-1][k] || (qt[k] > TLIM)) ? TLIM[STW-1:0] : qt[k][STW-1:0];
      stp[k]  = $signed({1'b0, step[k]});
      pt[k]   = PW'($signed(side_q[D-1][4 + k*C +: C]))
              + (side_q[D-1][4 + 3*C + k*C + C - 1] ? -stp[k] : stp[k]);
      if (pt[k] > PMAX) begin
        ps[k] = PMAX;
      end else if (pt[k] < PMIN) begin
        ps[k] = PMIN;
      end else begin
        ps[k] = pt[k];
      end
      hp[k*C +: C] = ps[k][C-1:0];
    end
    rsp.hit        = hitf;
    rsp.result_tag = side_q[D-1][4 + 6*C +: TagBits];
    rsp.bary_u     = hitf ? BaryBits'(qu) : '0;
    rsp.bary_v     = hitf ? BaryBits'(qv) : '0;
    rsp.hit_point  = hitf ? hp : '0;
  end

  // Output register with one skid entry
  always_comb begin
    pop           = out_valid_q & out_ready_i;
    arrive        = en & v_q[NS-1];
    out_from_skid = skid_valid_q & pop;
    out_from_pipe = arrive & (~out_valid_q | pop);
    skid_load     = arrive & out_valid_q & ~pop;
    out_valid_d   = out_from_skid | out_from_pipe | (out_valid_q & ~pop);
    skid_valid_d  = skid_load | (skid_valid_q & ~pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_from_skid) begin
      out_q <= skid_q;
    end else if (out_from_pipe) begin
      out_q <= rsp;
    end
    if (skid_load) begin
      skid_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output result");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!skid_valid_q ##1 skid_valid_q) |-> $past(out_valid_q && !out_ready_i))
    else $error("skid filled while output was not stalled");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v_q[0])
    else $error("accepted request missing from first stage");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_rsp_o.hit) |->
      (out_rsp_o.bary_u == '0 && out_rsp_o.bary_v == '0 && out_rsp_o.hit_point == '0))
    else $error("miss result carries nonzero fields");
`endif

endmodule

/* tb/tb_ray_triangle_intersection.sv */
// Self-checking testbench for ray_triangle_intersection (fixed-point hit test).
// Depends on rti_pkg and the DUT; predicts each result with wide signed integer math.
`timescale 1ns / 100ps

module tb_ray_triangle_intersection;
  import rti_pkg::*;

  typedef logic signed [159:0] wide_t;

  localparam int CoordHalf = 1 << 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  rti_req_t    in_req_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  rti_rsp_t    out_rsp_o;

  rti_rsp_t    pending_hits[$];
  logic [15:0] eps_shadow = 16'd1;
  bit          no_idle = 1'b0;
  int          errors = 0;

  ray_triangle_intersection dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop for a hung run
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(99) >= 23);
  end

  // Compute the expected result of one request
  function automatic rti_rsp_t predict_hit(rti_req_t r, logic [15:0] eps);
    wide_t o[3], d[3], p0[3], p1[3], p2[3], e1[3], e2[3], s[3], h[3], q[3];
    wide_t a, sh, dq, e2q, ew, num, qt, pt;
    wide_t tlim, cmax, cmin;
    rti_rsp_t res;
    logic [62:0] pk;
    res = '0;
    res.result_tag = r.face_tag;
    pk = '0;
    tlim = wide_t'(1) <<< 22;
    cmax = wide_t'(CoordHalf - 1);
    cmin = wide_t'(-CoordHalf);
    for (int k = 0; k < 3; k++) begin
      o[k]  = wide_t'($signed(r.ray_origin[k*21 +: 21]));
      d[k]  = wide_t'($signed(r.ray_direction[k*21 +: 21]));
      p0[k] = wide_t'($signed(r.vertex_zero[k*21 +: 21]));
      p1[k] = wide_t'($signed(r.vertex_one[k*21 +: 21]));
      p2[k] = wide_t'($signed(r.vertex_two[k*21 +: 21]));
    end
    for (int k = 0; k < 3; k++) begin
      e1[k] = p1[k] - p0[k];
      e2[k] = p2[k] - p0[k];
      s[k]  = o[k] - p0[k];
    end
    h[0] = d[1] * e2[2] - d[2] * e2[1];
    h[1] = d[2] * e2[0] - d[0] * e2[2];
    h[2] = d[0] * e2[1] - d[1] * e2[0];
    q[0] = s[1] * e1[2] - s[2] * e1[1];
    q[1] = s[2] * e1[0] - s[0] * e1[2];
    q[2] = s[0] * e1[1] - s[1] * e1[0];
    a   = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
    sh  = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
    dq  = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
    e2q = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    // Flip signs so the determinant is not negative
    if (a < 0) begin
      a = -a; sh = -sh; dq = -dq; e2q = -e2q;
    end
    ew = wide_t'(eps);
    if (a == 0 || a < (ew <<< 24)) return res;
    if (sh < 0 || sh > a) return res;
    if (dq < 0 || sh + dq > a) return res;
    if ((e2q <<< 12) <= a * ew) return res;
    // Hit point per coordinate: truncate, clamp the step, then saturate
    for (int k = 0; k < 3; k++) begin
      num = e2q * d[k];
      qt = ((num < 0) ? -num : num) / a;
      if (qt > tlim) qt = tlim;
      if (num < 0) qt = -qt;
      pt = o[k] + qt;
      if (pt > cmax) pt = cmax;
      if (pt < cmin) pt = cmin;
      pk[k*21 +: 21] = pt[20:0];
    end
    res.hit = 1'b1;
    num = (sh <<< 16) / a;
    res.bary_u = num[16:0];
    num = (dq <<< 16) / a;
    res.bary_v = num[16:0];
    res.hit_point = pk;
    return res;
  endfunction

  // Compare each accepted result with the oldest expectation
  always @(negedge clk_i) begin
    rti_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_rsp_o);
        errors++;
      end else begin
        want = pending_hits.pop_front();
        if (want.hit !== out_rsp_o.hit) begin
          $display("%0t: hit exp %b act %b", $time, want.hit, out_rsp_o.hit);
          errors++;
        end
        if (want.result_tag !== out_rsp_o.result_tag) begin
          $display("%0t: tag exp %h act %h", $time, want.result_tag, out_rsp_o.result_tag);
          errors++;
        end
        if (want.bary_u !== out_rsp_o.bary_u) begin
          $display("%0t: u exp %h act %h", $time, want.bary_u, out_rsp_o.bary_u);
          errors++;
        end
        if (want.bary_v !== out_rsp_o.bary_v) begin
          $display("%0t: v exp %h act %h", $time, want.bary_v, out_rsp_o.bary_v);
          errors++;
        end
        if (want.hit_point !== out_rsp_o.hit_point) begin
          $display("%0t: point exp %h act %h", $time, want.hit_point, out_rsp_o.hit_point);
          errors++;
        end
      end
    end
  end

  function automatic logic [62:0] vec3(int x, int y, int z);
    return {z[20:0], y[20:0], x[20:0]};
  endfunction

  function automatic int rnd_coord(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // Send one request, hold it until accepted, then record its expectation
  task automatic send_req(rti_req_t r);
    bit seen;
    while (!no_idle && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do begin
      @(negedge clk_i);
      seen = in_ready_o;
      @(posedge clk_i);
    end while (!seen);
    pending_hits.push_back(predict_hit(r, eps_shadow));
  endtask

  // Drain the pipe, then write epsilon
  task automatic set_epsilon(logic [15:0] val);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    eps_shadow = val;
  endtask

  function automatic rti_req_t make_req(int ox, int oy, int oz, int dx, int dy, int dz,
                                        int ax, int ay, int az, int bx, int by, int bz,
                                        int cx, int cy, int cz, logic [15:0] tag);
    rti_req_t r;
    r.ray_origin    = vec3(ox, oy, oz);
    r.ray_direction = vec3(dx, dy, dz);
    r.vertex_zero   = vec3(ax, ay, az);
    r.vertex_one    = vec3(bx, by, bz);
    r.vertex_two    = vec3(cx, cy, cz);
    r.face_tag      = tag;
    return r;
  endfunction

  // Well-formed ray aimed at a point inside a random triangle
  function automatic rti_req_t aimed_req();
    int p0[3], p1[3], p2[3], org[3], dir[3];
    int wa, wb, sc, tgt;
    rti_req_t r;
    wa = $urandom_range(256);
    wb = $urandom_range(256 - wa);
    sc = $urandom_range(2);
    for (int k = 0; k < 3; k++) begin
      p0[k]  = rnd_coord(1 << 17);
      p1[k]  = rnd_coord(1 << 17);
      p2[k]  = rnd_coord(1 << 17);
      org[k] = rnd_coord(1 << 18);
      tgt    = p0[k] + ((p1[k] - p0[k]) * wa + (p2[k] - p0[k]) * wb) / 256;
      dir[k] = (tgt - org[k]) >>> sc;
    end
    r.ray_origin    = vec3(org[0], org[1], org[2]);
    r.ray_direction = vec3(dir[0], dir[1], dir[2]);
    r.vertex_zero   = vec3(p0[0], p0[1], p0[2]);
    r.vertex_one    = vec3(p1[0], p1[1], p1[2]);
    r.vertex_two    = vec3(p2[0], p2[1], p2[2]);
    r.face_tag      = 16'($urandom_range(16'hFFFF));
    // Sometimes point the ray away or collapse the triangle
    case ($urandom_range(9))
      0: r.ray_direction = vec3(-dir[0], -dir[1], -dir[2]);
      1: r.vertex_two = r.vertex_zero;
      default: ;
    endcase
    return r;
  endfunction

  function automatic rti_req_t noise_req();
    rti_req_t r;
    r.ray_origin    = 63'({$urandom, $urandom});
    r.ray_direction = 63'({$urandom, $urandom});
    r.vertex_zero   = 63'({$urandom, $urandom});
    r.vertex_one    = 63'({$urandom, $urandom});
    r.vertex_two    = 63'({$urandom, $urandom});
    r.face_tag      = 16'($urandom_range(16'hFFFF));
    return r;
  endfunction

  task automatic test_directed();
    rti_req_t r;
    send_req('0);
    r = '1;
    send_req(r);
    // Unit triangle in z = 0, rays from z = 1
    send_req(make_req(1024, 1024, 4096, 0, 0, -4096, 0, 0, 0, 4096, 0, 0, 0, 4096, 0, 16'h0));
    send_req(make_req(1024, 1024, 4096, 0, 0, 4096, 0, 0, 0, 4096, 0, 0, 0, 4096, 0, 16'hFFFF));
    send_req(make_req(8192, 1024, 4096, 0, 0, -4096, 0, 0, 0, 4096, 0, 0, 0, 4096, 0, 16'h1));
    send_req(make_req(3000, 3000, 4096, 0, 0, -4096, 0, 0, 0, 4096, 0, 0, 0, 4096, 0, 16'h2));
    send_req(make_req(0, 0, 4096, 0, 0, -4096, 0, 0, 0, 4096, 0, 0, 0, 4096, 0, 16'h3));
    send_req(make_req(4096, 0, 4096, 0, 0, -4096, 0, 0, 0, 4096, 0, 0, 0, 4096, 0, 16'h4));
    // Origin on the plane: zero distance
    send_req(make_req(1024, 1024, 0, 0, 0, -4096, 0, 0, 0, 4096, 0, 0, 0, 4096, 0, 16'h5));
    // Ray parallel to the plane
    send_req(make_req(1024, 1024, 4096, 4096, 0, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0, 16'h6));
    // Tiny direction, distant triangle at the coordinate extremes
    send_req(make_req(0, 0, CoordHalf - 1, 0, 0, -1, -CoordHalf, -CoordHalf, -CoordHalf,
                      CoordHalf - 1, -CoordHalf, -CoordHalf, -CoordHalf, CoordHalf - 1,
                      -CoordHalf, 16'h7));
    send_req(make_req(0, 0, CoordHalf - 1, 1000, 1000, -1, -CoordHalf, -CoordHalf, 0,
                      CoordHalf - 1, -CoordHalf, 0, -CoordHalf, CoordHalf - 1, 0, 16'h8));
    // Small determinant near the epsilon threshold
    send_req(make_req(1, 1, 64, 0, 0, -1, 0, 0, 0, 4096, 0, 0, 0, 4096, 0, 16'h9));
    send_req(make_req(0, 0, 8, 0, 0, -1, 0, 0, 0, 4, 0, 0, 0, 4, 0, 16'hA));
  endtask

  task automatic test_random_mix(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 75) send_req(aimed_req());
      else send_req(noise_req());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    set_epsilon(16'd0);
    test_directed();
    test_random_mix(350);
    set_epsilon(16'hFFFF);
    test_directed();
    test_random_mix(300);
    set_epsilon(16'($urandom_range(16'hFFFF)));
    test_random_mix(350);
    set_epsilon(16'($urandom_range(255)));
    no_idle = 1'b1;
    test_random_mix(300);
    no_idle = 1'b0;
    set_epsilon(16'd1);
    test_random_mix(400);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/rti_pkg.sv
hdl/rti_div.sv
hdl/ray_triangle_intersection.sv
tb/tb_ray_triangle_intersection.sv
